// ===== hdl/kcf_pkg.sv =====
// ----------------------------------------------------------------------------
// kcf_pkg
// Types, key codes and register map shared by the key combination filter.
// ----------------------------------------------------------------------------
package kcf_pkg;

   localparam int KEY_SPACE     = 256;
   localparam int KEY_W         = $clog2(KEY_SPACE);
   localparam int HOTKEY_SLOTS  = 4;
   localparam int CODE_SLOTS    = 4;
   localparam int HELD_CNT_W    = KEY_W + 1;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int BLOCK_REGS    = 4;

   localparam logic [KEY_W-1:0] VK_TAB    = 8'h09;
   localparam logic [KEY_W-1:0] VK_ESC    = 8'h1B;
   localparam logic [KEY_W-1:0] VK_SHFT   = 8'h10;
   localparam logic [KEY_W-1:0] VK_CTRL   = 8'h11;
   localparam logic [KEY_W-1:0] VK_ALT    = 8'h12;
   localparam logic [KEY_W-1:0] VK_LWIN   = 8'h5B;
   localparam logic [KEY_W-1:0] VK_RWIN   = 8'h5C;
   localparam logic [KEY_W-1:0] VK_LSHFT  = 8'hA0;
   localparam logic [KEY_W-1:0] VK_RSHFT  = 8'hA1;
   localparam logic [KEY_W-1:0] VK_LCTRL  = 8'hA2;
   localparam logic [KEY_W-1:0] VK_RCTRL  = 8'hA3;
   localparam logic [KEY_W-1:0] VK_LALT   = 8'hA4;
   localparam logic [KEY_W-1:0] VK_RALT   = 8'hA5;

   localparam logic [1:0] MODE_DOWN = 2'd0;
   localparam logic [1:0] MODE_UP   = 2'd1;

   localparam logic [2:0] VERDICT_PASS     = 3'd0;
   localparam logic [2:0] VERDICT_HOTKEY   = 3'd1;
   localparam logic [2:0] VERDICT_BLOCKED  = 3'd2;
   localparam logic [2:0] VERDICT_ALT_TAB  = 3'd3;
   localparam logic [2:0] VERDICT_CTRL_ESC = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOTKEY_CODES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOTKEY_LENGTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKED_0     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKED_1     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKED_2     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKED_3     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_MODE     = 3'd6;

   localparam logic [31:0] HOTKEY_CODES_RESET  = 32'h4CA4A0A2;
   localparam logic [2:0]  HOTKEY_LENGTH_RESET = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key_code;
      logic [1:0]       mode;
   } req_type;

   typedef struct packed {
      logic       swallow;
      logic [2:0] verdict;
   } rsp_type;

   typedef struct packed {
      logic [31:0]                          hotkey_codes;
      logic [2:0]                           hotkey_length;
      logic [BLOCK_REGS*CSR_DATA_W-1:0]     block_bits;
      logic                                 user_mode_active;
   } cfg_type;

endpackage

// ===== hdl/kcf_judge.sv =====
// ----------------------------------------------------------------------------
// kcf_judge
// Hotkey match, forming-hotkey test and user-mode verdict for one event,
// evaluated against the held-key set as it stands after the event.
// ----------------------------------------------------------------------------
module kcf_judge import kcf_pkg::*; #(
   parameter int HOTKEY_SLOTS = kcf_pkg::HOTKEY_SLOTS
) (
   input  req_type                req,
   input  logic [KEY_SPACE-1:0]   held,
   input  logic [HELD_CNT_W-1:0]  held_count,
   input  cfg_type                cfg,
   output rsp_type                rsp
);

   localparam int SLOT_CNT_W = $clog2(HOTKEY_SLOTS + 1);

   logic [SLOT_CNT_W-1:0] slots_used;
   logic                  ctrl_held;
   logic                  shift_held;
   logic                  alt_held;
   logic                  fires;
   logic                  forming;
   logic                  blocked;

   function automatic logic is_ctrl(input logic [KEY_W-1:0] k);
      return (k == VK_LCTRL) || (k == VK_RCTRL) || (k == VK_CTRL);
   endfunction

   function automatic logic is_shift(input logic [KEY_W-1:0] k);
      return (k == VK_LSHFT) || (k == VK_RSHFT) || (k == VK_SHFT);
   endfunction

   function automatic logic is_alt(input logic [KEY_W-1:0] k);
      return (k == VK_LALT) || (k == VK_RALT) || (k == VK_ALT);
   endfunction

   assign ctrl_held  = held[VK_LCTRL] | held[VK_RCTRL] | held[VK_CTRL];
   assign shift_held = held[VK_LSHFT] | held[VK_RSHFT] | held[VK_SHFT];
   assign alt_held   = held[VK_LALT] | held[VK_RALT] | held[VK_ALT];
   assign blocked    = cfg.block_bits[req.key_code];

   always_comb begin
      if (int'(cfg.hotkey_length) > HOTKEY_SLOTS) begin
         slots_used = SLOT_CNT_W'(HOTKEY_SLOTS);
      end else begin
         slots_used = SLOT_CNT_W'(cfg.hotkey_length);
      end
   end

   always_comb begin
      logic [KEY_W-1:0]      code;
      logic [KEY_W-1:0]      trigger;
      logic                  mods_ok;
      logic                  all_held;
      logic                  member;
      logic [SLOT_CNT_W-1:0] hits;
      code     = '0;
      trigger  = '0;
      mods_ok  = 1'b1;
      all_held = 1'b1;
      member   = 1'b0;
      hits     = '0;
      for (int i = 0; i < HOTKEY_SLOTS; i++) begin
         if (i < int'(slots_used)) begin
            if (i < CODE_SLOTS) begin
               code = cfg.hotkey_codes[8*(i % CODE_SLOTS) +: 8];
            end else begin
               code = '0;
            end
            if (is_ctrl(code)) begin
               if (!ctrl_held) mods_ok = 1'b0;
            end else if (is_shift(code)) begin
               if (!shift_held) mods_ok = 1'b0;
            end else if (is_alt(code)) begin
               if (!alt_held) mods_ok = 1'b0;
            end else if ((code == VK_LWIN) || (code == VK_RWIN)) begin
               if (!held[code]) mods_ok = 1'b0;
            end else begin
               trigger = code;
            end
            if (!(held[code]
                  || ((code == VK_CTRL) && (held[VK_LCTRL] || held[VK_RCTRL]))
                  || ((code == VK_SHFT) && (held[VK_LSHFT] || held[VK_RSHFT]))
                  || ((code == VK_ALT) && (held[VK_LALT] || held[VK_RALT])))) begin
               all_held = 1'b0;
            end
            if (code == req.key_code) member = 1'b1;
            if ((code != req.key_code) && held[code]
                && (is_ctrl(code) || is_shift(code) || is_alt(code))) begin
               hits = hits + SLOT_CNT_W'(1);
            end
         end
      end
      fires = (slots_used != '0) && mods_ok && (trigger != '0)
              && (req.key_code == trigger) && all_held
              && (held_count == HELD_CNT_W'(slots_used));
      forming = member && (int'(slots_used) > 1)
                && (int'(hits) + 1 >= int'(slots_used));
   end

   always_comb begin
      rsp.verdict = VERDICT_PASS;
      if (req.mode == MODE_DOWN) begin
         if (fires) begin
            rsp.verdict = VERDICT_HOTKEY;
         end else if (cfg.user_mode_active) begin
            if (blocked && !forming) begin
               rsp.verdict = VERDICT_BLOCKED;
            end else if (alt_held && (req.key_code == VK_TAB)) begin
               rsp.verdict = VERDICT_ALT_TAB;
            end else if (ctrl_held && (req.key_code == VK_ESC)) begin
               rsp.verdict = VERDICT_CTRL_ESC;
            end
         end
      end
      rsp.swallow = (rsp.verdict != VERDICT_PASS);
   end

endmodule

// ===== hdl/key_combo_filter.sv =====
// ----------------------------------------------------------------------------
// key_combo_filter
// Keyboard event filter with held-key tracking and a configurable hotkey.
// ----------------------------------------------------------------------------
// Every accepted request yields exactly one response in the next cycle, and a
// new request is taken in every cycle while req_stall is low: the held-key set
// (256 flops plus a count) is updated and judged in the same cycle, and the
// verdict lands in a single response register. The only thing that slows the
// block is that register: while it holds an untaken response under rsp_stall,
// req_stall is raised. Configuration writes take effect at the next edge.
module key_combo_filter import kcf_pkg::*; #(
   parameter int HOTKEY_SLOTS = kcf_pkg::HOTKEY_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [KEY_SPACE-1:0]  held_ff;
   logic [KEY_SPACE-1:0]  held_in;
   logic [HELD_CNT_W-1:0] count_ff;
   logic [HELD_CNT_W-1:0] count_in;
   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               verdict;
   logic                  accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      if ((req_data.mode == MODE_DOWN) && !held_ff[req_data.key_code]) begin
         held_in[req_data.key_code] = 1'b1;
         count_in = count_ff + HELD_CNT_W'(1);
      end else if ((req_data.mode == MODE_UP) && held_ff[req_data.key_code]) begin
         held_in[req_data.key_code] = 1'b0;
         count_in = count_ff - HELD_CNT_W'(1);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HOTKEY_CODES:  cfg_in.hotkey_codes  = csr_wdata[31:0];
            CSR_HOTKEY_LENGTH: cfg_in.hotkey_length = csr_wdata[2:0];
            CSR_BLOCKED_0:     cfg_in.block_bits[0*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_BLOCKED_1:     cfg_in.block_bits[1*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_BLOCKED_2:     cfg_in.block_bits[2*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_BLOCKED_3:     cfg_in.block_bits[3*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_USER_MODE:     cfg_in.user_mode_active = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   kcf_judge #(
      .HOTKEY_SLOTS (HOTKEY_SLOTS)
   ) u_judge (
      .req        (req_data),
      .held       (held_in),
      .held_count (count_in),
      .cfg        (cfg_ff),
      .rsp        (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff                 <= '0;
         count_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.hotkey_codes     <= HOTKEY_CODES_RESET;
         cfg_ff.hotkey_length    <= HOTKEY_LENGTH_RESET;
         cfg_ff.block_bits       <= '0;
         cfg_ff.user_mode_active <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            held_ff      <= held_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= verdict;
      end
   end

endmodule

// ===== hdl/kcf_check.sv =====
// ----------------------------------------------------------------------------
// kcf_check
// Port-level checks for the key combination filter, bound to the top level.
// ----------------------------------------------------------------------------
module kcf_check import kcf_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input req_type                 req_data,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input rsp_type                 rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_swallow_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.swallow == (rsp_data.verdict != VERDICT_PASS)))
      else $error("swallow disagrees with verdict");

   a_non_down_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode != MODE_DOWN)
      |=> rsp_valid && (rsp_data.verdict == VERDICT_PASS))
      else $error("non key-down request not passed");

   a_esc_only: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.key_code != VK_ESC)
      |=> rsp_valid && (rsp_data.verdict != VERDICT_CTRL_ESC))
      else $error("Ctrl+Esc verdict on another key");

   a_no_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall && !rsp_valid)
      else $error("block not empty after reset");

endmodule

bind key_combo_filter kcf_check u_kcf_check (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_combo_filter. A driver feeds key events from a
// queue under random sender idling, a monitor checks each response against a
// built-in model of the held-key set, the hotkey rule and the user-mode
// blocking, under random receiver stalls. The run steps through several
// register settings, written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import kcf_pkg::*;

   localparam logic [1:0] MODE_OTHER = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int PHASES      = 8;
   localparam int PHASE_REQS  = 230;
   localparam int IDLE_PCT    = 31;
   localparam int CALM_PHASE  = 4;
   localparam int QUIET_LIMIT = 2000;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   key_combo_filter dut (.*);

   // model copy of the registers and the held-key set
   logic [31:0]          hk_codes  = HOTKEY_CODES_RESET;
   logic [2:0]           hk_len    = HOTKEY_LENGTH_RESET;
   logic [KEY_SPACE-1:0] block_map = '0;
   logic                 user_mode = 1'b1;
   bit                   key_down [KEY_SPACE];
   int                   down_count;

   // generator view of the held keys, as of the last queued request
   bit                   gen_down [KEY_SPACE];

   req_type key_events[$];
   rsp_type due_verdicts[$];

   int  errors, req_count, rsp_count, queued, csr_writes, settings_used, quiet;
   int  verdict_tally [5];
   bit  calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_ctrl_key(logic [7:0] k);
      return k == VK_CTRL || k == VK_LCTRL || k == VK_RCTRL;
   endfunction

   function automatic bit is_shift_key(logic [7:0] k);
      return k == VK_SHFT || k == VK_LSHFT || k == VK_RSHFT;
   endfunction

   function automatic bit is_alt_key(logic [7:0] k);
      return k == VK_ALT || k == VK_LALT || k == VK_RALT;
   endfunction

   function automatic bit is_group_key(logic [7:0] k);
      return is_ctrl_key(k) || is_shift_key(k) || is_alt_key(k);
   endfunction

   function automatic bit is_mod_key(logic [7:0] k);
      return is_group_key(k) || k == VK_LWIN || k == VK_RWIN;
   endfunction

   // any key of the Ctrl, Shift or Alt group of k held; else k itself
   function automatic bit group_held(logic [7:0] k);
      if (is_ctrl_key(k))
         return key_down[VK_CTRL] || key_down[VK_LCTRL] || key_down[VK_RCTRL];
      if (is_shift_key(k))
         return key_down[VK_SHFT] || key_down[VK_LSHFT] || key_down[VK_RSHFT];
      if (is_alt_key(k))
         return key_down[VK_ALT] || key_down[VK_LALT] || key_down[VK_RALT];
      return key_down[k];
   endfunction

   function automatic int slots_in_use();
      return (hk_len > HOTKEY_SLOTS) ? HOTKEY_SLOTS : int'(hk_len);
   endfunction

   function automatic bit hotkey_hit(logic [7:0] vk);
      int          n;
      logic [7:0]  r;
      logic [7:0]  trigger;
      n = slots_in_use();
      trigger = 8'h00;
      for (int i = 0; i < n; i++) begin
         r = hk_codes[8*i +: 8];
         if (is_mod_key(r)) begin
            if (!group_held(r))
               return 1'b0;
         end else begin
            trigger = r;
         end
      end
      if (trigger == 8'h00 || vk != trigger)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         r = hk_codes[8*i +: 8];
         if (!key_down[r] &&
             !((r == VK_CTRL || r == VK_SHFT || r == VK_ALT) && group_held(r)))
            return 1'b0;
      end
      return down_count == n;
   endfunction

   function automatic bit hotkey_forming(logic [7:0] vk);
      int          n;
      int          hits;
      bit          member;
      logic [7:0]  a;
      n = slots_in_use();
      hits = 0;
      member = 1'b0;
      for (int i = 0; i < n; i++)
         if (hk_codes[8*i +: 8] == vk)
            member = 1'b1;
      if (!member)
         return 1'b0;
      for (int i = 0; i < n; i++) begin
         a = hk_codes[8*i +: 8];
         if (a != vk && key_down[a] && is_group_key(a))
            hits++;
      end
      return n > 1 && hits + 1 >= n;
   endfunction

   function automatic rsp_type predict_filter(req_type req);
      logic [7:0] vk;
      logic [2:0] verdict;
      rsp_type    res;
      vk = req.key_code;
      verdict = VERDICT_PASS;
      if (req.mode == MODE_DOWN && !key_down[vk]) begin
         key_down[vk] = 1'b1;
         down_count++;
      end else if (req.mode == MODE_UP && key_down[vk]) begin
         key_down[vk] = 1'b0;
         down_count--;
      end
      if (req.mode == MODE_DOWN) begin
         if (slots_in_use() > 0 && hotkey_hit(vk))
            verdict = VERDICT_HOTKEY;
         else if (user_mode) begin
            if (block_map[vk] && !hotkey_forming(vk))
               verdict = VERDICT_BLOCKED;
            else if (vk == VK_TAB && group_held(VK_ALT))
               verdict = VERDICT_ALT_TAB;
            else if (vk == VK_ESC && group_held(VK_CTRL))
               verdict = VERDICT_CTRL_ESC;
         end
      end
      res.swallow = (verdict != VERDICT_PASS);
      res.verdict = verdict;
      return res;
   endfunction

   function automatic logic [7:0] modifier_key();
      case ($urandom_range(10))
         0:       return VK_CTRL;
         1:       return VK_SHFT;
         2:       return VK_ALT;
         3:       return VK_LCTRL;
         4:       return VK_RCTRL;
         5:       return VK_LSHFT;
         6:       return VK_RSHFT;
         7:       return VK_LALT;
         8:       return VK_RALT;
         9:       return VK_LWIN;
         default: return VK_RWIN;
      endcase
   endfunction

   function automatic logic [7:0] special_key();
      case ($urandom_range(5))
         0:       return VK_TAB;
         1:       return VK_ESC;
         2, 3:    return modifier_key();
         default: return hk_codes[8*$urandom_range(3) +: 8];
      endcase
   endfunction

   function automatic logic [31:0] random_hotkey(int n);
      logic [31:0] c;
      logic [7:0]  t;
      c = $urandom;
      for (int i = 0; i < n - 1; i++)
         c[8*i +: 8] = ($urandom_range(5) == 0) ? 8'($urandom) : modifier_key();
      do
         t = 8'($urandom_range(1, 255));
      while (is_mod_key(t));
      if (n > 0)
         c[8*(n-1) +: 8] = ($urandom_range(9) == 0) ? 8'h00 : t;
      return c;
   endfunction

   task automatic queue_event(logic [7:0] code, logic [1:0] mode);
      req_type r;
      r.key_code = code;
      r.mode = mode;
      key_events.push_back(r);
      if (mode == MODE_DOWN)
         gen_down[code] = 1'b1;
      else if (mode == MODE_UP)
         gen_down[code] = 1'b0;
      queued++;
   endtask

   task automatic release_all();
      int base;
      base = $urandom_range(KEY_SPACE - 1);
      for (int i = 0; i < KEY_SPACE; i++)
         if (gen_down[(base + i) % KEY_SPACE])
            queue_event(8'((base + i) % KEY_SPACE), MODE_UP);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_HOTKEY_CODES:  hk_codes = value[31:0];
         CSR_HOTKEY_LENGTH: hk_len = value[2:0];
         CSR_BLOCKED_0:     block_map[63:0] = value;
         CSR_BLOCKED_1:     block_map[127:64] = value;
         CSR_BLOCKED_2:     block_map[191:128] = value;
         CSR_BLOCKED_3:     block_map[255:192] = value;
         CSR_USER_MODE:     user_mode = value[0];
         default:           ;
      endcase
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (key_events.size() != 0 || req_valid || due_verdicts.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic flag_error(string msg);
      errors++;
      if (errors <= 10)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : drive_keys
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_verdicts.push_back(predict_filter(req_data));
            req_count++;
         end
         if (!req_valid || !req_stall) begin
            if (key_events.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data <= key_events.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_verdicts
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (due_verdicts.size() == 0) begin
               flag_error($sformatf("response %0d with none expected: swallow %0d verdict %0d",
                                    rsp_count, rsp_data.swallow, rsp_data.verdict));
            end else begin
               want = due_verdicts.pop_front();
               if (rsp_data.swallow !== want.swallow || rsp_data.verdict !== want.verdict)
                  flag_error($sformatf({"response %0d: expected swallow %0d verdict %0d,",
                                        " got swallow %0d verdict %0d"}, rsp_count,
                                       want.swallow, want.verdict,
                                       rsp_data.swallow, rsp_data.verdict));
               else if (want.verdict <= VERDICT_CTRL_ESC)
                  verdict_tally[want.verdict]++;
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Timeout: no request, response or register write for %0d cycles",
                  QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      logic [7:0]           code;
      logic [1:0]           mode;
      logic [31:0]          codes_val;
      logic [2:0]           len_val;
      logic [KEY_SPACE-1:0] blk;
      logic                 um_val;
      logic [63:0]          junk;
      int                   n, trig_at, cnt, j, tmp, pick, base;
      int                   order [4];

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            // reset hotkey is LCtrl LShift LAlt L
            queue_event(VK_LCTRL, MODE_DOWN);
            queue_event(VK_LSHFT, MODE_DOWN);
            queue_event(VK_LALT, MODE_DOWN);
            queue_event(8'h4C, MODE_DOWN);
            queue_event(VK_TAB, MODE_DOWN);
            queue_event(VK_ESC, MODE_DOWN);
            queue_event(VK_LCTRL, MODE_DOWN);
            queue_event(8'h4C, MODE_UP);
            queue_event(VK_TAB, MODE_UP);
            queue_event(VK_ESC, MODE_UP);
            queue_event(VK_LSHFT, MODE_UP);
            queue_event(VK_LALT, MODE_UP);
            queue_event(VK_LCTRL, MODE_UP);
            queue_event(8'h55, MODE_UP);
            queue_event(8'hFF, MODE_OTHER);
            queue_event(8'h00, MODE_SPARE);
            queue_event(VK_CTRL, MODE_DOWN);
            queue_event(VK_ESC, MODE_DOWN);
            queue_event(VK_ESC, MODE_UP);
            queue_event(VK_CTRL, MODE_UP);
            queue_event(VK_RALT, MODE_DOWN);
            queue_event(VK_TAB, MODE_DOWN);
            queue_event(VK_TAB, MODE_UP);
            queue_event(VK_RALT, MODE_UP);
         end else begin
            case (phase)
               2: begin
                  codes_val = 32'hFFFF_FFFF;
                  len_val = 3'd7;
                  blk = '1;
                  um_val = 1'b0;
               end
               3: begin
                  codes_val = 32'h0;
                  len_val = 3'd0;
                  blk = '0;
                  um_val = 1'b1;
               end
               default: begin
                  n = $urandom_range(1, HOTKEY_SLOTS);
                  codes_val = random_hotkey(n);
                  len_val = (n == HOTKEY_SLOTS && $urandom_range(1)) ?
                            3'($urandom_range(4, 7)) : 3'(n);
                  if (phase != 1 && $urandom_range(7) == 0)
                     len_val = 3'd0;
                  for (int r = 0; r < BLOCK_REGS; r++)
                     case ($urandom_range(3))
                        0:       blk[64*r +: 64] = '0;
                        1:       blk[64*r +: 64] = '1;
                        2:       blk[64*r +: 64] = {$urandom, $urandom};
                        default: blk[64*r +: 64] = {$urandom, $urandom} & {$urandom, $urandom}
                                                   & {$urandom, $urandom};
                     endcase
                  // block hotkey keys so the forming exemption is exercised
                  if (phase == 1 || $urandom_range(1))
                     for (int i = 0; i < CODE_SLOTS; i++)
                        blk[codes_val[8*i +: 8]] = 1'b1;
                  if ($urandom_range(1)) begin
                     blk[VK_TAB] = 1'b0;
                     blk[VK_ESC] = 1'b0;
                  end
                  um_val = (phase == 1) || ($urandom_range(3) != 0);
               end
            endcase
            junk = {$urandom, $urandom};
            write_csr(CSR_HOTKEY_CODES, {junk[63:32], codes_val});
            write_csr(CSR_HOTKEY_LENGTH, {junk[63:3], len_val});
            write_csr(CSR_BLOCKED_0, blk[63:0]);
            write_csr(CSR_BLOCKED_1, blk[127:64]);
            write_csr(CSR_BLOCKED_2, blk[191:128]);
            write_csr(CSR_BLOCKED_3, blk[255:192]);
            write_csr(CSR_USER_MODE, {junk[63:1], um_val});
         end
         settings_used++;
         calm = (phase == CALM_PHASE);
         base = queued;

         while (queued - base < PHASE_REQS) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
               // hotkey attempt: clean set, modifiers in random order, trigger last
               release_all();
               n = slots_in_use();
               trig_at = -1;
               for (int i = 0; i < n; i++)
                  if (!is_mod_key(hk_codes[8*i +: 8]))
                     trig_at = i;
               cnt = 0;
               for (int i = 0; i < n; i++)
                  if (i != trig_at) begin
                     order[cnt] = i;
                     cnt++;
                  end
               for (int i = cnt - 1; i > 0; i--) begin
                  j = $urandom_range(i);
                  tmp = order[i];
                  order[i] = order[j];
                  order[j] = tmp;
               end
               if (trig_at >= 0) begin
                  order[cnt] = trig_at;
                  cnt++;
               end
               for (int i = 0; i < cnt; i++) begin
                  code = hk_codes[8*order[i] +: 8];
                  if ($urandom_range(1)) begin
                     if (code == VK_CTRL)
                        code = $urandom_range(1) ? VK_LCTRL : VK_RCTRL;
                     else if (code == VK_SHFT)
                        code = $urandom_range(1) ? VK_LSHFT : VK_RSHFT;
                     else if (code == VK_ALT)
                        code = $urandom_range(1) ? VK_LALT : VK_RALT;
                  end
                  if (order[i] == trig_at && $urandom_range(9) == 0)
                     queue_event(special_key(), MODE_DOWN);
                  if ($urandom_range(11) != 0)
                     queue_event(code, MODE_DOWN);
               end
               if (trig_at >= 0 && $urandom_range(3) == 0)
                  queue_event(hk_codes[8*trig_at +: 8], MODE_DOWN);
               if ($urandom_range(1))
                  release_all();
            end else if (pick < 7) begin
               // Alt+Tab and Ctrl+Esc style chords
               if ($urandom_range(1))
                  code = ($urandom_range(2) == 0) ? VK_ALT : ($urandom_range(1) ? VK_LALT : VK_RALT);
               else
                  code = ($urandom_range(2) == 0) ? VK_CTRL : ($urandom_range(1) ? VK_LCTRL : VK_RCTRL);
               queue_event(code, MODE_DOWN);
               tmp = $urandom_range(1) ? VK_TAB : VK_ESC;
               queue_event(8'(tmp), MODE_DOWN);
               queue_event(8'(tmp), MODE_UP);
               if ($urandom_range(1))
                  queue_event(code, MODE_UP);
            end else begin
               repeat ($urandom_range(1, 8)) begin
                  code = $urandom_range(1) ? 8'($urandom_range(255)) : special_key();
                  tmp = $urandom_range(19);
                  mode = (tmp < 9) ? MODE_DOWN : (tmp < 18) ? MODE_UP :
                         (tmp == 18) ? MODE_OTHER : MODE_SPARE;
                  queue_event(code, mode);
               end
            end
         end
         // hold the sender until every response of this setting is back
         wait_idle();
      end

      calm = 1'b0;
      repeat (4) @(posedge clock);
      if (due_verdicts.size() != 0)
         flag_error($sformatf("%0d responses never arrived", due_verdicts.size()));
      $display("Checked %0d key events across %0d register settings (%0d register writes).",
               req_count, settings_used, csr_writes);
      $display("Verdicts: %0d passed, %0d hotkey, %0d blocked, %0d alt-tab, %0d ctrl-esc.",
               verdict_tally[VERDICT_PASS], verdict_tally[VERDICT_HOTKEY],
               verdict_tally[VERDICT_BLOCKED], verdict_tally[VERDICT_ALT_TAB],
               verdict_tally[VERDICT_CTRL_ESC]);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kcf_pkg.sv
hdl/kcf_judge.sv
hdl/key_combo_filter.sv
hdl/kcf_check.sv
test/testbench.sv
